[rtl/core/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// No dependencies; include by bare file name inside a module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/ffba_pkg.sv]
// Package for the first-fit block allocator: sizes, table entry type, codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int POOL_BYTES = 524288;
  localparam int GRAN       = 16;

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int SIZE_W  = 20;
  localparam int WANT_W  = SIZE_W + 1;
  localparam int ADDR_W  = 32;
  localparam int ENTRY_W = SIZE_W + 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SIZE_W-1:0] blk_size_t;
  typedef logic [WANT_W-1:0] want_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam cnt_t      MAX_CNT    = CNT_W'(MAX_BLOCKS);
  localparam blk_size_t POOL_SIZE  = SIZE_W'(POOL_BYTES);
  localparam addr_t     BASE_RESET = 32'd65536;

  typedef enum logic [0:0] {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef struct packed {
    logic      is_free;
    blk_size_t size;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_NEXT,
    ST_SHIFT,
    ST_FIX,
    ST_DONE
  } state_t;

  // Round a byte count up to the allocation granule.
  function automatic want_t round_up(input blk_size_t req);
    want_t sum;
    sum = {1'b0, req} + WANT_W'(GRAN - 1);
    return sum & ~WANT_W'(GRAN - 1);
  endfunction

endpackage

`default_nettype wire

[rtl/core/ffba_req_if.sv]
// Request channel of the allocator: valid/ready with func, size and address.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ffba_req_if;
  import ffba_pkg::*;

  logic        valid;
  logic        ready;
  logic        func;
  blk_size_t   request_size;
  addr_t       free_address;

  modport source (output valid, output func, output request_size, output free_address,
                  input ready);
  modport sink   (input valid, input func, input request_size, input free_address,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/ffba_rsp_if.sv]
// Response channel of the allocator: valid/ready with block address and status.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ffba_rsp_if;
  import ffba_pkg::*;

  logic  valid;
  logic  ready;
  addr_t block_address;
  logic  ok;

  modport source (output valid, output block_address, output ok, input ready);
  modport sink   (input valid, input block_address, input ok, output ready);
endinterface

`default_nettype wire

[rtl/core/ffba_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/first_fit_block_allocator_top.sv]
// Top level of the first-fit block allocator: sequencer around the block table.
// Depends on ffba_pkg, ffba_req_if, ffba_rsp_if, ffba_ram, assert_macros.svh.
//
//   channel   dir   beat / write
//   req       in    func, request_size, free_address (valid/ready)
//   rsp       out   block_address, ok (valid/ready)
//   cfg       in    cfg_wdata -> pool_base when cfg_we
//
// An allocate whose first fit is entry k scans entries 0 to k, shifts the
// entries above k up by one (none when k is the last entry), writes the free
// remainder in a fix-up and hands off; a free scans to its entry, merges it
// with free neighbors and shifts the rest down. The single read port of the
// block table reads one entry a cycle; a full-table allocate skips the scan.
// After rst the block writes table entry 0 in its init state with req.ready low.
// The result register holds a beat until taken; the next request is accepted
// meanwhile and finishes once that register is free.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire ffba_pkg::addr_t cfg_wdata,
  ffba_req_if.sink             req,
  ffba_rsp_if.source           rsp
);
  import ffba_pkg::*;

`include "assert_macros.svh"

  state_t    state, state_next;
  cnt_t      count;
  cnt_t      cnt_new;
  addr_t     pool_base;
  func_t     op;
  want_t     want;
  addr_t     faddr;
  addr_t     at;
  idx_t      ev_k;
  entry_t    cur;
  entry_t    prv;
  logic      res_ok;
  addr_t     res_addr;
  logic      rsp_valid;
  logic      rsp_ok;
  addr_t     rsp_addr;

  logic      sh_act;
  logic      sh_pend;
  logic      sh_up;
  idx_t      sh_rd;
  idx_t      sh_stop;
  idx_t      sh_wa;
  logic [1:0] sh_gap;

  logic                ram_we;
  idx_t                ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  idx_t                ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  entry_t    rd_e;
  want_t     want_in;
  logic      scan_last;
  logic      alloc_hit;
  logic      free_hit;
  logic      scan_hit;
  logic      nx_free;
  logic      pv_free;
  blk_size_t merge_size;
  logic [1:0] gap;
  cnt_t      src_start;
  idx_t      merge_at;
  logic      rsp_load;

  ffba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_e      = entry_t'(ram_rdata);
  assign want_in   = round_up(req.request_size);
  assign scan_last = (CNT_W'(ev_k) + CNT_W'(1)) == count;
  assign alloc_hit = rd_e.is_free && (want < {1'b0, rd_e.size});
  assign free_hit  = (faddr == at);
  assign scan_hit  = (op == FUNC_FREE) ? free_hit : alloc_hit;

  // Neighbors of a freed entry: next is in the read data, previous was held.
  assign nx_free    = !scan_last && rd_e.is_free;
  assign pv_free    = (ev_k != '0) && prv.is_free;
  assign merge_size = cur.size + (nx_free ? rd_e.size : '0) + (pv_free ? prv.size : '0);
  assign gap        = {1'b0, nx_free} + {1'b0, pv_free};
  assign src_start  = CNT_W'(ev_k) + CNT_W'(1) + CNT_W'(nx_free);
  assign merge_at   = pv_free ? ev_k - IDX_W'(1) : ev_k;

  assign rsp_load = !rsp_valid || rsp.ready;

  assign req.ready         = (state == ST_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.block_address = rsp_addr;
  assign rsp.ok            = rsp_ok;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: state_next = ST_IDLE;
      ST_IDLE: begin
        if (req.valid) begin
          if (func_t'(req.func) == FUNC_ALLOC && count >= MAX_CNT) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        priority if (scan_hit && op == FUNC_FREE) begin
          state_next = ST_NEXT;
        end else if (scan_hit) begin
          state_next = scan_last ? ST_FIX : ST_SHIFT;
        end else if (scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_NEXT: begin
        if (gap == 2'd0 || src_start == count) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (!sh_act) begin
          state_next = sh_up ? ST_FIX : ST_DONE;
        end
      end
      ST_FIX:  state_next = ST_DONE;
      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = entry_t'{is_free: 1'b1, size: POOL_SIZE};
      end
      ST_SCAN: begin
        ram_raddr = ev_k + IDX_W'(1);
        if (scan_hit && op == FUNC_ALLOC) begin
          ram_we    = 1'b1;
          ram_waddr = ev_k;
          ram_wdata = entry_t'{is_free: 1'b0, size: want[SIZE_W-1:0]};
        end
      end
      ST_NEXT: begin
        ram_we    = 1'b1;
        ram_waddr = merge_at;
        ram_wdata = entry_t'{is_free: 1'b1, size: merge_size};
      end
      ST_SHIFT: begin
        ram_raddr = sh_rd;
        ram_we    = sh_pend;
        ram_waddr = sh_wa;
        ram_wdata = ram_rdata;
      end
      ST_FIX: begin
        ram_we    = 1'b1;
        ram_waddr = ev_k + IDX_W'(1);
        ram_wdata = entry_t'{is_free: 1'b1, size: cur.size - want[SIZE_W-1:0]};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      count     <= CNT_W'(1);
      pool_base <= BASE_RESET;
      rsp_valid <= 1'b0;
      sh_act    <= 1'b0;
      sh_pend   <= 1'b0;
    end else begin
      state   <= state_next;
      sh_pend <= (state == ST_SHIFT) && sh_act;
      if (cfg_we) begin
        pool_base <= cfg_wdata;
      end
      if (rsp_valid && rsp.ready && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op       <= func_t'(req.func);
            want     <= want_in;
            faddr    <= req.free_address;
            at       <= pool_base;
            ev_k     <= '0;
            res_ok   <= 1'b0;
            res_addr <= '0;
            cnt_new  <= count;
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            cur <= rd_e;
            if (op == FUNC_ALLOC) begin
              res_ok   <= 1'b1;
              res_addr <= at;
              cnt_new  <= count + CNT_W'(1);
              if (!scan_last) begin
                sh_act  <= 1'b1;
                sh_up   <= 1'b1;
                sh_rd   <= IDX_W'(count - CNT_W'(1));
                sh_stop <= ev_k + IDX_W'(1);
              end
            end
          end else begin
            at   <= at + ADDR_W'(rd_e.size);
            ev_k <= ev_k + IDX_W'(1);
            prv  <= rd_e;
          end
        end
        ST_NEXT: begin
          res_ok  <= 1'b1;
          cnt_new <= count - CNT_W'(gap);
          if (gap != 2'd0 && src_start != count) begin
            sh_act  <= 1'b1;
            sh_up   <= 1'b0;
            sh_rd   <= src_start[IDX_W-1:0];
            sh_stop <= IDX_W'(count - CNT_W'(1));
            sh_gap  <= gap;
          end
        end
        ST_SHIFT: begin
          if (sh_act) begin
            sh_wa <= sh_up ? sh_rd + IDX_W'(1) : sh_rd - IDX_W'(sh_gap);
            if (sh_rd == sh_stop) begin
              sh_act <= 1'b0;
            end else begin
              sh_rd <= sh_up ? sh_rd - IDX_W'(1) : sh_rd + IDX_W'(1);
            end
          end
        end
        ST_DONE: begin
          if (rsp_load) begin
            rsp_valid <= 1'b1;
            rsp_addr  <= res_addr;
            rsp_ok    <= res_ok;
            count     <= cnt_new;
          end
        end
        default: begin
          sh_act <= sh_act;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, count != '0 && count <= MAX_CNT, "count range")
  `ASSERT_IMPL(a_scan_in_table, clk, rst, state == ST_SCAN, CNT_W'(ev_k) < count, "scan past end")
  `ASSERT_IMPL(a_shift_sep, clk, rst, state == ST_SHIFT && sh_pend, sh_wa != sh_rd, "overlap")
  `ASSERT_NEXT(a_idle_count, clk, rst, state == ST_IDLE, count == $past(count), "count moved")

endmodule

`default_nettype wire
